@@ sv/lgs_pkg.sv @@
`default_nettype none

package lgs_pkg;

  // grid geometry
  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int CNT_W    = $clog2(MAX_ROWS + 1);
  localparam int CCNT_W   = $clog2(MAX_COLS + 1);

  // fixed field widths of the ports
  localparam int IDX_W  = 6;
  localparam int CELL_W = 64;
  localparam int GEN_W  = 16;
  localparam int CFG_W  = 7;

  // request queue depth, a power of two
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // configuration register indexes
  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  // classified request from the front to the back
  typedef struct packed {
    logic                is_step;
    logic                load_ok;
    logic [ROW_W-1:0]    addr;
    logic [MAX_COLS-1:0] cells;
  } cmd_t;

  // active grid size, clamped
  typedef struct packed {
    logic [CNT_W-1:0]    nrows;
    logic [MAX_COLS-1:0] cmask;
  } cfg_t;

  // clamp a row count into 1..MAX_ROWS
  function automatic logic [CNT_W-1:0] clamp_rows(input logic [CFG_W-1:0] v);
    logic [CNT_W-1:0] res;
    if (v == '0) begin
      res = CNT_W'(1);
    end else if (32'(v) > MAX_ROWS) begin
      res = CNT_W'(MAX_ROWS);
    end else begin
      res = CNT_W'(v);
    end
    return res;
  endfunction

  // column mask for a column count, clamped into 1..MAX_COLS
  function automatic logic [MAX_COLS-1:0] col_mask(input logic [CFG_W-1:0] v);
    logic [MAX_COLS-1:0] res;
    logic [CCNT_W-1:0]   n;
    if (v == '0) begin
      n = CCNT_W'(1);
    end else if (32'(v) > MAX_COLS) begin
      n = CCNT_W'(MAX_COLS);
    end else begin
      n = CCNT_W'(v);
    end
    for (int c = 0; c < MAX_COLS; c++) begin
      res[c] = (CCNT_W'(c) < n);
    end
    return res;
  endfunction

  // one row of the next generation, b3/s23 over three masked rows
  function automatic logic [MAX_COLS-1:0] life_next(input logic [MAX_COLS-1:0] up,
                                                    input logic [MAX_COLS-1:0] mid,
                                                    input logic [MAX_COLS-1:0] dn,
                                                    input logic [MAX_COLS-1:0] cmask);
    logic [MAX_COLS+1:0] u;
    logic [MAX_COLS+1:0] m;
    logic [MAX_COLS+1:0] d;
    logic [3:0]          n;
    logic [MAX_COLS-1:0] res;
    u = {1'b0, up, 1'b0};
    m = {1'b0, mid, 1'b0};
    d = {1'b0, dn, 1'b0};
    for (int c = 0; c < MAX_COLS; c++) begin
      n = 4'(u[c]) + 4'(u[c+1]) + 4'(u[c+2]) + 4'(m[c]) + 4'(m[c+2])
        + 4'(d[c]) + 4'(d[c+1]) + 4'(d[c+2]);
      res[c] = (n == 4'd3) || (m[c+1] && (n == 4'd2));
    end
    return res & cmask;
  endfunction

endpackage

`default_nettype wire

@@ sv/lgs_ram.sv @@
`default_nettype none

module lgs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port that holds when not read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ sv/lgs_front.sv @@
`default_nettype none

module lgs_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         kind,
  input  wire logic [lgs_pkg::IDX_W-1:0]    row_index,
  input  wire logic [lgs_pkg::CELL_W-1:0]   row_cells,
  output lgs_pkg::cmd_t                     cmd,
  output logic                              cmd_valid,
  input  wire logic                         cmd_pop
);

  lgs_pkg::cmd_t                    queue [lgs_pkg::QDEPTH];
  lgs_pkg::cmd_t                    incoming;
  logic [lgs_pkg::QPTR_W-1:0]       wr_ptr;
  logic [lgs_pkg::QPTR_W-1:0]       rd_ptr;
  logic [lgs_pkg::QCNT_W-1:0]       count;
  logic                             push;

  // classify the request: steps carry nothing, loads get a range check
  always_comb begin
    incoming.is_step = kind;
    incoming.load_ok = ((lgs_pkg::IDX_W + 1)'(row_index) <
                        (lgs_pkg::IDX_W + 1)'(lgs_pkg::MAX_ROWS));
    incoming.addr    = row_index[lgs_pkg::ROW_W-1:0];
    incoming.cells   = row_cells[lgs_pkg::MAX_COLS-1:0];
  end

  assign in_stall  = (count == lgs_pkg::QCNT_W'(lgs_pkg::QDEPTH));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (count != '0);
  assign cmd       = queue[rd_ptr];

  // queue payload
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= incoming;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (cmd_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, cmd_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= lgs_pkg::QCNT_W'(lgs_pkg::QDEPTH))
    else $error("request queue over capacity");
  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("empty queue with pointers apart");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> (count != '0))
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

@@ sv/lgs_back.sv @@
`default_nettype none

module lgs_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire lgs_pkg::cfg_t                cfg,
  input  wire lgs_pkg::cmd_t                cmd,
  input  wire logic                         cmd_valid,
  output logic                              cmd_pop,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [lgs_pkg::IDX_W-1:0]    out_row,
  output logic      [lgs_pkg::CELL_W-1:0]   out_cells,
  output logic      [lgs_pkg::GEN_W-1:0]    generation,
  output logic                              last_row
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_PRIME = 3'b010,
    ST_ROW   = 3'b100
  } state_t;

  state_t                          state;
  state_t                          state_next;
  logic [lgs_pkg::MAX_ROWS-1:0]    row_valid;
  logic [lgs_pkg::CNT_W-1:0]       r;
  logic [lgs_pkg::MAX_COLS-1:0]    up;
  logic [lgs_pkg::MAX_COLS-1:0]    mid;
  logic [lgs_pkg::GEN_W-1:0]       gen;
  logic                            rd_ok;
  logic [lgs_pkg::MAX_COLS-1:0]    rdata;
  logic [lgs_pkg::MAX_COLS-1:0]    rd_row;
  logic [lgs_pkg::MAX_COLS-1:0]    next_cells;
  logic                            re;
  logic [lgs_pkg::CNT_W-1:0]       rd_addr;
  logic                            we;
  logic [lgs_pkg::ROW_W-1:0]       waddr;
  logic [lgs_pkg::MAX_COLS-1:0]    wdata;
  logic                            out_free;
  logic                            is_last;
  logic                            advance;

  lgs_ram #(
    .WIDTH (lgs_pkg::MAX_COLS),
    .DEPTH (lgs_pkg::MAX_ROWS)
  ) u_grid (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (rd_addr[lgs_pkg::ROW_W-1:0]),
    .rdata (rdata)
  );

  // row coming out of the grid memory, dead if never written or out of range
  assign rd_row     = rd_ok ? (rdata & cfg.cmask) : '0;
  assign next_cells = lgs_pkg::life_next(up, mid, rd_row, cfg.cmask);
  assign out_free   = !out_valid || !out_stall;
  assign is_last    = ((r + 1'b1) == cfg.nrows);
  assign advance    = (state == ST_ROW) && out_free;

  // sequencer: loads write straight from idle, steps sweep the rows with a 3-row window
  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    re         = 1'b0;
    rd_addr    = '0;
    we         = 1'b0;
    waddr      = cmd.addr;
    wdata      = cmd.cells;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.is_step) begin
            re         = 1'b1;
            state_next = ST_PRIME;
          end else begin
            we      = cmd.load_ok;
            cmd_pop = 1'b1;
          end
        end
      end
      ST_PRIME: begin
        re         = 1'b1;
        rd_addr    = lgs_pkg::CNT_W'(1);
        state_next = ST_ROW;
      end
      ST_ROW: begin
        if (out_free) begin
          we    = 1'b1;
          waddr = r[lgs_pkg::ROW_W-1:0];
          wdata = next_cells;
          if (is_last) begin
            cmd_pop    = 1'b1;
            state_next = ST_IDLE;
          end else begin
            re      = 1'b1;
            rd_addr = r + lgs_pkg::CNT_W'(2);
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      row_valid <= '0;
      gen       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == ST_IDLE) && cmd_valid && cmd.is_step) begin
        gen <= gen + 1'b1;
      end
      // row valid bits: set on write, rows past the active count die at step end
      if ((state == ST_IDLE) && we) begin
        row_valid[cmd.addr] <= 1'b1;
      end else if (advance) begin
        for (int i = 0; i < lgs_pkg::MAX_ROWS; i++) begin
          if (lgs_pkg::CNT_W'(i) == r) begin
            row_valid[i] <= 1'b1;
          end else if (is_last && !(lgs_pkg::CNT_W'(i) < cfg.nrows)) begin
            row_valid[i] <= 1'b0;
          end
        end
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // window, row counter, read tag and output register
  always_ff @(posedge clk) begin
    if (re) begin
      rd_ok <= (rd_addr < cfg.nrows) && row_valid[rd_addr[lgs_pkg::ROW_W-1:0]];
    end
    if (state == ST_PRIME) begin
      up  <= '0;
      mid <= rd_row;
      r   <= '0;
    end else if (advance) begin
      up         <= mid;
      mid        <= rd_row;
      r          <= r + 1'b1;
      out_row    <= lgs_pkg::IDX_W'(r);
      out_cells  <= lgs_pkg::CELL_W'(next_cells);
      generation <= gen;
      last_row   <= is_last;
    end
  end

`ifndef ASSERT_OFF
  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("sequencer state not one-hot");
  a_step_holds_cmd: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_PRIME) || (state == ST_ROW)) |-> (cmd_valid && cmd.is_step))
    else $error("step sweep without its request at queue head");
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_ROW) && we && re) |->
      (waddr != rd_addr[lgs_pkg::ROW_W-1:0]))
    else $error("sweep reads the row it writes");
`endif

endmodule

`default_nettype wire

@@ sv/life_generation_step_top.sv @@
`default_nettype none

// channel  | direction | handshake             | payload
// ---------+-----------+-----------------------+----------------------------------------
// in       | request   | in_valid / in_stall   | kind, row_index, row_cells
// out      | result    | out_valid / out_stall | out_row, out_cells, generation, last_row
// cfg      | write     | cfg_we                | cfg_index, cfg_data
//
// a load request is written from the idle state in the back end; a step primes the
// window, then sweeps one row a cycle through the grid memory read port while not stalled.
// a two-entry request queue lets the input run ahead of a busy back end.
// synchronous reset clears the grid (per-row valid bits), the generation count
// and sets both row and column counts to 64; no clearing pass is needed.
// out_stall freezes the sweep in place; in_stall is high only when the queue is full.

module life_generation_step_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_index,
  input  wire logic [lgs_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         kind,
  input  wire logic [lgs_pkg::IDX_W-1:0]    row_index,
  input  wire logic [lgs_pkg::CELL_W-1:0]   row_cells,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [lgs_pkg::IDX_W-1:0]    out_row,
  output logic      [lgs_pkg::CELL_W-1:0]   out_cells,
  output logic      [lgs_pkg::GEN_W-1:0]    generation,
  output logic                              last_row
);

  lgs_pkg::cfg_t  cfg;
  lgs_pkg::cmd_t  cmd;
  logic           cmd_valid;
  logic           cmd_pop;

  // configuration registers, stored clamped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.nrows <= lgs_pkg::CNT_W'(lgs_pkg::MAX_ROWS);
      cfg.cmask <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        lgs_pkg::CFG_ROWS: cfg.nrows <= lgs_pkg::clamp_rows(cfg_data);
        lgs_pkg::CFG_COLS: cfg.cmask <= lgs_pkg::col_mask(cfg_data);
        default:           cfg.nrows <= cfg.nrows;
      endcase
    end
  end

  lgs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .row_index (row_index),
    .row_cells (row_cells),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  lgs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (cmd),
    .cmd_valid  (cmd_valid),
    .cmd_pop    (cmd_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_row    (out_row),
    .out_cells  (out_cells),
    .generation (generation),
    .last_row   (last_row)
  );

endmodule

`default_nettype wire

@@ bench/life_step_tb_pkg.sv @@
`timescale 1ns / 100ps

package life_step_tb_pkg;

  // request kinds on the input channel
  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_STEP = 1'b1
  } req_kind_e;

endpackage

@@ bench/life_generation_step_checker.sv @@
`timescale 1ns / 100ps

module life_generation_step_checker
  import lgs_pkg::*;
  import life_step_tb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              kind,
  input  logic [IDX_W-1:0]  row_index,
  input  logic [CELL_W-1:0] row_cells,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [IDX_W-1:0]  out_row,
  input  logic [CELL_W-1:0] out_cells,
  input  logic [GEN_W-1:0]  generation,
  input  logic              last_row,
  output int                fails,
  output int                rows_pending,
  output int                loads_seen,
  output int                steps_seen,
  output int                rows_checked
);

  // one emitted row of the next generation
  typedef struct packed {
    logic [IDX_W-1:0]  row;
    logic [CELL_W-1:0] cells;
    logic [GEN_W-1:0]  gen;
    logic              last_flag;
  } row_result_t;

  row_result_t       next_rows[$];
  logic [CELL_W-1:0] board [MAX_ROWS];
  logic [GEN_W-1:0]  gen_total;
  logic [CFG_W-1:0]  rows_reg;
  logic [CFG_W-1:0]  cols_reg;
  int                mismatch_total;
  int                load_total;
  int                step_total;
  int                checked_total;

  // register value as the block uses it: zero means one, big values saturate
  function automatic int active_count(input logic [CFG_W-1:0] v, input int limit);
    int n;
    n = int'(v);
    if (n < 1) n = 1;
    if (n > limit) n = limit;
    return n;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatch_total++;
  endtask

  // b3/s23 over the active window, cells outside it are dead
  task automatic advance_board();
    logic [CELL_W-1:0] cur [MAX_ROWS];
    logic [CELL_W-1:0] nxt;
    row_result_t       res;
    int                nrows;
    int                ncols;
    int                live;
    int                rr;
    int                cc;
    nrows = active_count(rows_reg, MAX_ROWS);
    ncols = active_count(cols_reg, MAX_COLS);
    for (int r = 0; r < MAX_ROWS; r++) begin
      cur[r] = '0;
      for (int c = 0; c < ncols; c++) begin
        if (r < nrows) cur[r][c] = board[r][c];
      end
    end
    for (int r = 0; r < MAX_ROWS; r++) begin
      nxt = '0;
      if (r < nrows) begin
        for (int c = 0; c < ncols; c++) begin
          live = 0;
          for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
              rr = r + dr;
              cc = c + dc;
              if (!(dr == 0 && dc == 0) && rr >= 0 && rr < nrows && cc >= 0 && cc < ncols)
                live += int'(cur[rr][cc]);
            end
          end
          nxt[c] = (live == 3) || (cur[r][c] && live == 2);
        end
      end
      board[r] = nxt;
    end
    gen_total++;
    // every active row comes out, in order
    for (int r = 0; r < nrows; r++) begin
      res.row       = IDX_W'(r);
      res.cells     = board[r];
      res.gen       = gen_total;
      res.last_flag = (r == nrows - 1);
      next_rows.push_back(res);
    end
  endtask

  // compare one accepted row with the oldest expected one
  task automatic check_row();
    row_result_t want;
    if (next_rows.size() == 0) begin
      report_mismatch($sformatf("unexpected row %0d gen %0d", out_row, generation));
    end else begin
      want = next_rows.pop_front();
      if (out_row !== want.row)
        report_mismatch($sformatf("out_row got %0d want %0d", out_row, want.row));
      if (out_cells !== want.cells)
        report_mismatch($sformatf("row %0d out_cells got %h want %h",
                                  want.row, out_cells, want.cells));
      if (generation !== want.gen)
        report_mismatch($sformatf("row %0d generation got %0d want %0d",
                                  want.row, generation, want.gen));
      if (last_row !== want.last_flag)
        report_mismatch($sformatf("row %0d last_row got %b want %b",
                                  want.row, last_row, want.last_flag));
      checked_total++;
    end
  endtask

  // track config writes, requests and results at each edge
  always @(posedge clk) begin
    if (rst) begin
      next_rows.delete();
      for (int r = 0; r < MAX_ROWS; r++) board[r] = '0;
      gen_total      = '0;
      rows_reg       = CFG_W'(MAX_ROWS);
      cols_reg       = CFG_W'(MAX_COLS);
      mismatch_total = 0;
      load_total     = 0;
      step_total     = 0;
      checked_total  = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_ROWS) rows_reg = cfg_data;
        else if (cfg_index == CFG_COLS) cols_reg = cfg_data;
      end
      if (in_valid && !in_stall) begin
        if (kind == KIND_STEP) begin
          advance_board();
          step_total++;
        end else begin
          if (int'(row_index) < MAX_ROWS) board[row_index] = row_cells;
          load_total++;
        end
      end
      if (out_valid && !out_stall) check_row();
    end
    fails        <= mismatch_total;
    rows_pending <= next_rows.size();
    loads_seen   <= load_total;
    steps_seen   <= step_total;
    rows_checked <= checked_total;
  end

endmodule

@@ bench/life_generation_step_top_tb.sv @@
`timescale 1ns / 100ps

module life_generation_step_top_tb;
  import lgs_pkg::*;
  import life_step_tb_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int STALL_LIMIT  = 4000;
  localparam int QUIET_CYCLES = 8;
  localparam int TAIL_CYCLES  = 80;
  localparam int SET_QUOTA    = 28;

  logic              clk        = 1'b0;
  logic              rst        = 1'b1;
  logic              cfg_we     = 1'b0;
  logic              cfg_index  = CFG_ROWS;
  logic [CFG_W-1:0]  cfg_data   = '0;
  logic              in_valid   = 1'b0;
  logic              in_stall;
  logic              kind       = KIND_LOAD;
  logic [IDX_W-1:0]  row_index  = '0;
  logic [CELL_W-1:0] row_cells  = '0;
  logic              out_valid;
  logic              out_stall  = 1'b0;
  logic [IDX_W-1:0]  out_row;
  logic [CELL_W-1:0] out_cells;
  logic [GEN_W-1:0]  generation;
  logic              last_row;

  int fails;
  int rows_pending;
  int loads_seen;
  int steps_seen;
  int rows_checked;

  int idle_pct     = 0;
  int stall_pct    = 0;
  int rows_now     = MAX_ROWS;
  int items_sent   = 0;
  int grid_changes = 0;
  int quiet_count  = 0;

  life_generation_step_top u_dut (.*);

  life_generation_step_checker u_checker (.*);

  always #(HALF_PERIOD) clk = ~clk;

  // receiver stalls at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_count <= 0;
    end else if (quiet_count >= STALL_LIMIT) begin
      $display("watchdog: nothing accepted for %0d cycles, %0d rows outstanding",
               STALL_LIMIT, rows_pending);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  function automatic logic [CELL_W-1:0] rand_cells(input int thin);
    logic [CELL_W-1:0] w;
    w = {$urandom, $urandom};
    repeat (thin) w &= {$urandom, $urandom};
    return w;
  endfunction

  // present one request, with a random gap first, and wait until accepted
  task automatic send_req(input req_kind_e k, input logic [IDX_W-1:0] idx,
                          input logic [CELL_W-1:0] cells);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= k;
    row_index <= idx;
    row_cells <= cells;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // step requests carry random don't-care payload
  task automatic step_req();
    send_req(KIND_STEP, IDX_W'($urandom), rand_cells(0));
  endtask

  // hold off until every expected row is back, then let queued loads finish
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (rows_pending != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // write both size registers, block must be idle
  task automatic set_grid(input logic [CFG_W-1:0] nrows, input logic [CFG_W-1:0] ncols);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ROWS;
    cfg_data  <= nrows;
    @(posedge clk);
    cfg_index <= CFG_COLS;
    cfg_data  <= ncols;
    @(posedge clk);
    cfg_we <= 1'b0;
    rows_now = (nrows == '0) ? 1 : ((int'(nrows) > MAX_ROWS) ? MAX_ROWS : int'(nrows));
    grid_changes++;
  endtask

  // mostly full seeded boards followed by steps, with stray loads and lone steps
  task automatic run_random_set(input int quota);
    int target;
    int pick;
    int thin;
    target = items_sent + quota;
    while (items_sent < target) begin
      pick = $urandom_range(9);
      if (pick < 7) begin
        thin = $urandom_range(3);
        for (int r = 0; r < rows_now && items_sent < target; r++) begin
          send_req(KIND_LOAD, IDX_W'(r), rand_cells(thin));
        end
        repeat ($urandom_range(1, 3)) step_req();
        if ($urandom_range(4) == 0) drain();
      end else if (pick < 9) begin
        send_req(KIND_LOAD, IDX_W'($urandom_range(63)), rand_cells(0));
      end else begin
        step_req();
      end
    end
  endtask

  function automatic logic [CFG_W-1:0] pick_count(input int typical_max);
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return '0;
    if (sel == 1) return CFG_W'(64);
    if (sel == 2) return CFG_W'($urandom_range(65, 127));
    return CFG_W'($urandom_range(1, typical_max));
  endfunction

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    idle_pct  = 27;
    stall_pct = 85;

    // full width at reset size, live cells on all four borders
    send_req(KIND_LOAD, 6'd0, '1);
    send_req(KIND_LOAD, 6'd63, '1);
    send_req(KIND_LOAD, 6'd1, 64'h8000_0000_0000_0001);
    send_req(KIND_LOAD, 6'd62, 64'hE000_0000_0000_0000);
    step_req();
    step_req();

    // zero counts act as a one-cell board
    drain();
    set_grid('0, '0);
    send_req(KIND_LOAD, 6'd0, '1);
    step_req();

    // oversized counts saturate at the maximum
    drain();
    set_grid(CFG_W'(127), CFG_W'(127));
    send_req(KIND_LOAD, 6'd31, 64'h0000_0001_C000_0000);
    step_req();

    // blinker in a 3x3 box, bits past the box and a row outside it
    drain();
    set_grid(CFG_W'(3), CFG_W'(3));
    send_req(KIND_LOAD, 6'd0, '0);
    send_req(KIND_LOAD, 6'd1, '1);
    send_req(KIND_LOAD, 6'd2, '0);
    send_req(KIND_LOAD, 6'd5, '1);
    step_req();
    step_req();

    // single column, then single row
    drain();
    set_grid(CFG_W'(64), CFG_W'(1));
    send_req(KIND_LOAD, 6'd10, '1);
    send_req(KIND_LOAD, 6'd11, '1);
    send_req(KIND_LOAD, 6'd12, '1);
    step_req();
    drain();
    set_grid(CFG_W'(1), CFG_W'(64));
    send_req(KIND_LOAD, 6'd0, '1);
    step_req();

    // random part in three idling phases
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct  = (phase == 0) ? 27 : ((phase == 1) ? 85 : 0);
      stall_pct = (phase == 0) ? 85 : ((phase == 1) ? 27 : 0);
      for (int s = 0; s < 4; s++) begin
        drain();
        set_grid(pick_count(12), pick_count(64));
        run_random_set(SET_QUOTA);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d row loads and %0d generation steps, %0d result rows compared",
             loads_seen, steps_seen, rows_checked);
    $display("over %0d board sizes incl. zero, one, full and oversized counts, three stall mixes",
             grid_changes);
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
